[hdl/rwkc_pkg.sv]
`timescale 1ns / 1ps
// rwkc_pkg: shared types, register indexes and arithmetic helpers
// for the rainbow wave key color unit; depends on nothing

package rwkc_pkg;

  // keys at or above this index give black
  localparam int unsigned MAX_KEYS = 256;

  localparam int unsigned FRAC_W  = 24;  // phase fraction bits, Q0.24 turns
  localparam int unsigned LEVEL_W = 9;   // Q1.8 levels, 256 = full
  localparam int unsigned CHAN_W  = 8;
  localparam int unsigned CFG_W   = 32;
  localparam int unsigned CIDX_W  = 3;
  localparam int unsigned C16_W   = 17;  // v*s up to 65536
  localparam int unsigned Q40_W   = 41;  // channel value up to 2^40

  typedef enum logic [CIDX_W-1:0] {
    CFG_WAVE_SPEED = 3'd0,
    CFG_WAVE_SCALE = 3'd1,
    CFG_SATURATION = 3'd2,
    CFG_BRIGHTNESS = 3'd3,
    CFG_TINT_COLOR = 3'd4,
    CFG_TINT_EN    = 3'd5,
    CFG_TINT_WGT   = 3'd6
  } cfg_idx_t;

  // hue sector, 60 degrees each
  typedef enum logic [2:0] {
    SEC_RED_YEL = 3'd0,
    SEC_YEL_GRN = 3'd1,
    SEC_GRN_CYN = 3'd2,
    SEC_CYN_BLU = 3'd3,
    SEC_BLU_MAG = 3'd4,
    SEC_MAG_RED = 3'd5
  } sector_t;

  // levels above full clamp to full
  function automatic logic [LEVEL_W-1:0] sat_level(input logic [LEVEL_W-1:0] lvl);
    return lvl[LEVEL_W-1] ? 9'd256 : lvl;
  endfunction

  // (q * 255) >> 40 done as (q << 8) - q, q never exceeds 2^40
  function automatic logic [CHAN_W-1:0] to_byte(input logic [Q40_W-1:0] q);
    logic [Q40_W+7:0] scaled;
    scaled = {q, 8'd0} - {8'd0, q};
    return scaled[Q40_W+6:Q40_W-1];
  endfunction

  // a*(256-w) + b*w, rounded half up, w already clamped to 256
  function automatic logic [CHAN_W-1:0] blend(input logic [CHAN_W-1:0]  a,
                                               input logic [CHAN_W-1:0]  b,
                                               input logic [LEVEL_W-1:0] w);
    logic [LEVEL_W-1:0] wa;
    logic [17:0]        sum;
    wa  = 9'd256 - w;
    sum = 18'(a * wa) + 18'(b * w) + 18'd128;
    return sum[15:8];
  endfunction

endpackage

[hdl/rainbow_wave_key_color_unit.sv]
`timescale 1ns / 1ps
// rainbow_wave_key_color_unit: per-key rainbow color, hsv to rgb with tint
// depends on rwkc_pkg
//
//  channel  | ports                                   | direction
//  ---------+-----------------------------------------+----------
//  request  | in_valid, in_stall, in_key_index,       | in
//           | in_time_ticks                           |
//  result   | out_valid, out_stall, out_red,          | out
//           | out_green, out_blue                     |
//  config   | cfg_we, cfg_index, cfg_wdata            | in
//
// five register stages: phase products, phase sum and sector split,
// chroma times fraction, channel scaling, tint blend into the output register
// one request per cycle while the result side is not stalled; the 24x24 tick
// product and the 17x25 chroma product set the stage depth
// each stage holds while the one after it is full and stalled, so bubbles
// close up and a waiting result does not block new requests
// synchronous active-low reset empties the pipe and loads register defaults

module rainbow_wave_key_color_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  // request channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [7:0]                          in_key_index,
  input  logic [31:0]                         in_time_ticks,
  // result channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [rwkc_pkg::CHAN_W-1:0]         out_red,
  output logic [rwkc_pkg::CHAN_W-1:0]         out_green,
  output logic [rwkc_pkg::CHAN_W-1:0]         out_blue,
  // register write port
  input  logic                                cfg_we,
  input  logic [rwkc_pkg::CIDX_W-1:0]         cfg_index,
  input  logic [rwkc_pkg::CFG_W-1:0]          cfg_wdata
);

  import rwkc_pkg::*;

  // ---------------------------------------------------------------- registers
  // only the low 24 bits of speed and scale reach the wrapped phase
  logic [FRAC_W-1:0]  wave_speed_r;
  logic [FRAC_W-1:0]  wave_scale_r;
  logic [LEVEL_W-1:0] sat_lvl_r;
  logic [LEVEL_W-1:0] bri_lvl_r;
  logic [23:0]        tint_color_r;
  logic               tint_en_r;
  logic [LEVEL_W-1:0] tint_wgt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wave_speed_r <= '0;
      wave_scale_r <= '0;
      sat_lvl_r    <= 9'd256;
      bri_lvl_r    <= 9'd256;
      tint_color_r <= '0;
      tint_en_r    <= 1'b0;
      tint_wgt_r   <= 9'd128;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_WAVE_SPEED: wave_speed_r <= cfg_wdata[FRAC_W-1:0];
        CFG_WAVE_SCALE: wave_scale_r <= cfg_wdata[FRAC_W-1:0];
        CFG_SATURATION: sat_lvl_r    <= cfg_wdata[LEVEL_W-1:0];
        CFG_BRIGHTNESS: bri_lvl_r    <= cfg_wdata[LEVEL_W-1:0];
        CFG_TINT_COLOR: tint_color_r <= cfg_wdata[23:0];
        CFG_TINT_EN:    tint_en_r    <= cfg_wdata[0];
        CFG_TINT_WGT:   tint_wgt_r   <= cfg_wdata[LEVEL_W-1:0];
        default: ;  // unknown index, write dropped
      endcase
    end
  end

  // ---------------------------------------------------------------- flow control
  logic s1_v_r, s2_v_r, s3_v_r, s4_v_r, out_v_r;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;

  assign rdy5     = !out_v_r || !out_stall;
  assign rdy4     = !s4_v_r  || rdy5;
  assign rdy3     = !s3_v_r  || rdy4;
  assign rdy2     = !s2_v_r  || rdy3;
  assign rdy1     = !s1_v_r  || rdy2;
  assign in_stall = !rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      s3_v_r  <= 1'b0;
      s4_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (rdy1) s1_v_r  <= in_valid;
      if (rdy2) s2_v_r  <= s1_v_r;
      if (rdy3) s3_v_r  <= s2_v_r;
      if (rdy4) s4_v_r  <= s3_v_r;
      if (rdy5) out_v_r <= s4_v_r;
    end
  end

  // ---------------------------------------------------------------- stage 1
  // phase products, wrapped to the fraction (sign bits fall off above bit 23)
  logic [FRAC_W-1:0] s1_pkey_r, s1_pkey_nxt;
  logic [FRAC_W-1:0] s1_ptick_r, s1_ptick_nxt;
  logic              s1_hit_r, s1_hit_nxt;

  always_comb begin
    s1_pkey_nxt  = FRAC_W'(in_key_index * wave_scale_r);
    s1_ptick_nxt = FRAC_W'(in_time_ticks[FRAC_W-1:0] * wave_speed_r);
    s1_hit_nxt   = 32'(in_key_index) < MAX_KEYS;
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      s1_pkey_r  <= s1_pkey_nxt;
      s1_ptick_r <= s1_ptick_nxt;
      s1_hit_r   <= s1_hit_nxt;
    end
  end

  // ---------------------------------------------------------------- stage 2
  // phase sum, times six, split into sector and fraction; chroma and floor
  sector_t           s2_sec_r, s2_sec_nxt;
  logic [FRAC_W-1:0] s2_frac_r, s2_frac_nxt;
  logic [C16_W-1:0]  s2_c16_r, s2_c16_nxt;
  logic [C16_W-1:0]  s2_m16_r, s2_m16_nxt;
  logic              s2_hit_r;

  logic [FRAC_W-1:0]  phase;
  logic [FRAC_W+2:0]  p6;
  logic [LEVEL_W-1:0] sat_v, bri_v;

  always_comb begin
    phase       = s1_pkey_r + s1_ptick_r;
    p6          = {1'b0, phase, 2'b00} + {2'b00, phase, 1'b0};
    s2_sec_nxt  = sector_t'(p6[FRAC_W+2:FRAC_W]);
    s2_frac_nxt = p6[FRAC_W-1:0];
    sat_v       = sat_level(sat_lvl_r);
    bri_v       = sat_level(bri_lvl_r);
    s2_c16_nxt  = C16_W'(bri_v * sat_v);
    // v*256 - c, never negative since s is at most full
    s2_m16_nxt  = {bri_v, 8'd0} - s2_c16_nxt;
  end

  always_ff @(posedge clk) begin
    if (rdy2) begin
      s2_sec_r  <= s2_sec_nxt;
      s2_frac_r <= s2_frac_nxt;
      s2_c16_r  <= s2_c16_nxt;
      s2_m16_r  <= s2_m16_nxt;
      s2_hit_r  <= s1_hit_r;
    end
  end

  // ---------------------------------------------------------------- stage 3
  // second component: chroma times rising or falling ramp
  logic [Q40_W-1:0] s3_x40_r, s3_x40_nxt;
  sector_t          s3_sec_r;
  logic [C16_W-1:0] s3_c16_r, s3_m16_r;
  logic             s3_hit_r;

  logic [FRAC_W:0]   ramp;
  logic [Q40_W:0]    xprod;

  always_comb begin
    ramp       = s2_sec_r[0] ? ((FRAC_W+1)'(1) << FRAC_W) - {1'b0, s2_frac_r}
                             : {1'b0, s2_frac_r};
    xprod      = (Q40_W+1)'(s2_c16_r * ramp);
    s3_x40_nxt = xprod[Q40_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rdy3) begin
      s3_x40_r <= s3_x40_nxt;
      s3_sec_r <= s2_sec_r;
      s3_c16_r <= s2_c16_r;
      s3_m16_r <= s2_m16_r;
      s3_hit_r <= s2_hit_r;
    end
  end

  // ---------------------------------------------------------------- stage 4
  // place components by sector, add the floor, scale to a byte
  logic [CHAN_W-1:0] s4_r_r, s4_r_nxt;
  logic [CHAN_W-1:0] s4_g_r, s4_g_nxt;
  logic [CHAN_W-1:0] s4_b_r, s4_b_nxt;
  logic              s4_hit_r;

  logic [Q40_W-1:0] c40, m40, rq, gq, bq;

  always_comb begin
    c40 = {s3_c16_r, {FRAC_W{1'b0}}};
    m40 = {s3_m16_r, {FRAC_W{1'b0}}};
    rq  = '0;
    gq  = '0;
    bq  = '0;
    case (s3_sec_r)
      SEC_RED_YEL: begin rq = c40;      gq = s3_x40_r; end
      SEC_YEL_GRN: begin rq = s3_x40_r; gq = c40;      end
      SEC_GRN_CYN: begin gq = c40;      bq = s3_x40_r; end
      SEC_CYN_BLU: begin gq = s3_x40_r; bq = c40;      end
      SEC_BLU_MAG: begin rq = s3_x40_r; bq = c40;      end
      default:     begin rq = c40;      bq = s3_x40_r; end
    endcase
    // keys out of range come out black
    s4_r_nxt = s3_hit_r ? to_byte(rq + m40) : '0;
    s4_g_nxt = s3_hit_r ? to_byte(gq + m40) : '0;
    s4_b_nxt = s3_hit_r ? to_byte(bq + m40) : '0;
  end

  always_ff @(posedge clk) begin
    if (rdy4) begin
      s4_r_r   <= s4_r_nxt;
      s4_g_r   <= s4_g_nxt;
      s4_b_r   <= s4_b_nxt;
      s4_hit_r <= s3_hit_r;
    end
  end

  // ---------------------------------------------------------------- stage 5
  // optional tint blend into the output register
  logic [CHAN_W-1:0]  out_red_r, out_red_nxt;
  logic [CHAN_W-1:0]  out_green_r, out_green_nxt;
  logic [CHAN_W-1:0]  out_blue_r, out_blue_nxt;
  logic [LEVEL_W-1:0] tint_w;
  logic               do_tint;

  always_comb begin
    tint_w        = sat_level(tint_wgt_r);
    do_tint       = tint_en_r && s4_hit_r;
    out_red_nxt   = do_tint ? blend(s4_r_r, tint_color_r[23:16], tint_w) : s4_r_r;
    out_green_nxt = do_tint ? blend(s4_g_r, tint_color_r[15:8], tint_w)  : s4_g_r;
    out_blue_nxt  = do_tint ? blend(s4_b_r, tint_color_r[7:0], tint_w)   : s4_b_r;
  end

  always_ff @(posedge clk) begin
    if (rdy5) begin
      out_red_r   <= out_red_nxt;
      out_green_r <= out_green_nxt;
      out_blue_r  <= out_blue_nxt;
    end
  end

  assign out_valid = out_v_r;
  assign out_red   = out_red_r;
  assign out_green = out_green_r;
  assign out_blue  = out_blue_r;

  // ---------------------------------------------------------------- assertions
  // an empty first stage always takes a request
  a_take_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_v_r |-> !in_stall)
    else $error("request refused with empty first stage");

  // the sector split never leaves the six hue sectors
  a_sector_range: assert property (@(posedge clk) disable iff (!rst_n)
    s2_v_r |-> (s2_sec_r <= SEC_MAG_RED))
    else $error("hue sector out of range");

  // out-of-range keys are black before the tint stage
  a_black_miss: assert property (@(posedge clk) disable iff (!rst_n)
    (s4_v_r && !s4_hit_r) |-> (s4_r_r == '0 && s4_g_r == '0 && s4_b_r == '0))
    else $error("out-of-range key not black");

  // a result waiting behind a stalled output stays in stage four
  a_hold_behind_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_stall && s4_v_r) |=> (s4_v_r && $stable(s4_r_r)))
    else $error("stage four lost data under stall");

endmodule

[test/rwkc_checker.sv]
`timescale 1ns / 1ps
// rwkc_checker: watches the request, result and register ports of the
// rainbow wave key color unit, predicts each color and compares; uses rwkc_pkg

module rwkc_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_stall,
  input  logic [7:0]                  in_key_index,
  input  logic [31:0]                 in_time_ticks,
  input  logic                        out_valid,
  input  logic                        out_stall,
  input  logic [rwkc_pkg::CHAN_W-1:0] out_red,
  input  logic [rwkc_pkg::CHAN_W-1:0] out_green,
  input  logic [rwkc_pkg::CHAN_W-1:0] out_blue,
  input  logic                        cfg_we,
  input  logic [rwkc_pkg::CIDX_W-1:0] cfg_index,
  input  logic [rwkc_pkg::CFG_W-1:0]  cfg_wdata,
  output int                          fail_count,
  output int                          pending
);
  import rwkc_pkg::*;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } color_t;

  typedef struct {
    logic [7:0]  key;
    logic [31:0] ticks;
    color_t      rgb;
  } key_color_t;

  // shadow copy of the register file
  logic [31:0]        speed_q;
  logic [31:0]        scale_q;
  logic [LEVEL_W-1:0] sat_q;
  logic [LEVEL_W-1:0] bri_q;
  logic [23:0]        tint_q;
  logic               tint_on_q;
  logic [LEVEL_W-1:0] wgt_q;

  key_color_t color_q[$];
  key_color_t head;
  int         fails = 0;

  assign fail_count = fails;

  function automatic logic [LEVEL_W-1:0] clamp_full(input logic [LEVEL_W-1:0] lvl);
    return (lvl > 9'd256) ? 9'd256 : lvl;
  endfunction

  function automatic logic [7:0] q40_to_chan(input logic [63:0] q);
    logic [63:0] r;
    r = (q * 64'd255) >> 40;
    return (r > 64'd255) ? 8'd255 : r[7:0];
  endfunction

  function automatic logic [7:0] mix_tint(input logic [7:0] a, input logic [7:0] b,
                                          input logic [LEVEL_W-1:0] w);
    logic [31:0] r;
    r = (32'(a) * (32'd256 - 32'(w)) + 32'(b) * 32'(w) + 32'd128) >> 8;
    return (r > 32'd255) ? 8'd255 : r[7:0];
  endfunction

  function automatic color_t key_color(input logic [7:0] key, input logic [31:0] ticks);
    logic [63:0]        phase, p6, f, s, v, c16, c40, m40, x40, r, g, b;
    logic [LEVEL_W-1:0] w;
    sector_t            sec;
    color_t             res;
    res = '0;
    if (32'(key) < MAX_KEYS) begin
      // only the fraction survives, so negative phases wrap upward
      phase = (64'(key) * {{32{scale_q[31]}}, scale_q}
             + 64'(ticks) * {{32{speed_q[31]}}, speed_q}) & 64'hFF_FFFF;
      p6  = phase * 64'd6;
      sec = sector_t'(p6[26:24]);
      f   = p6 & 64'hFF_FFFF;
      s   = 64'(clamp_full(sat_q));
      v   = 64'(clamp_full(bri_q));
      c16 = v * s;
      c40 = c16 << 24;
      m40 = ((v << 8) - c16) << 24;
      // falling edge of the ramp in odd sectors
      x40 = p6[24] ? c16 * ((64'd1 << 24) - f) : c16 * f;
      r = '0;
      g = '0;
      b = '0;
      case (sec)
        SEC_RED_YEL: begin r = c40; g = x40; end
        SEC_YEL_GRN: begin r = x40; g = c40; end
        SEC_GRN_CYN: begin g = c40; b = x40; end
        SEC_CYN_BLU: begin g = x40; b = c40; end
        SEC_BLU_MAG: begin r = x40; b = c40; end
        default:     begin r = c40; b = x40; end
      endcase
      res.red   = q40_to_chan(r + m40);
      res.green = q40_to_chan(g + m40);
      res.blue  = q40_to_chan(b + m40);
      if (tint_on_q) begin
        w = clamp_full(wgt_q);
        res.red   = mix_tint(res.red,   tint_q[23:16], w);
        res.green = mix_tint(res.green, tint_q[15:8],  w);
        res.blue  = mix_tint(res.blue,  tint_q[7:0],   w);
      end
    end
    return res;
  endfunction

  task automatic check_chan(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch key=%0d ticks=%h expected=%h actual=%h",
               $time, name, head.key, head.ticks, want, got);
      fails++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      speed_q   <= '0;
      scale_q   <= '0;
      sat_q     <= 9'd256;
      bri_q     <= 9'd256;
      tint_q    <= '0;
      tint_on_q <= 1'b0;
      wgt_q     <= 9'd128;
      color_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (color_q.size() == 0) begin
          $display("%0t: color with no request pending expected=none actual=%h %h %h",
                   $time, out_red, out_green, out_blue);
          fails++;
        end else begin
          head = color_q.pop_front();
          check_chan("red",   head.rgb.red,   out_red);
          check_chan("green", head.rgb.green, out_green);
          check_chan("blue",  head.rgb.blue,  out_blue);
        end
      end
      if (in_valid && !in_stall)
        color_q.push_back('{in_key_index, in_time_ticks, key_color(in_key_index, in_time_ticks)});
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_WAVE_SPEED: speed_q   <= cfg_wdata;
          CFG_WAVE_SCALE: scale_q   <= cfg_wdata;
          CFG_SATURATION: sat_q     <= cfg_wdata[LEVEL_W-1:0];
          CFG_BRIGHTNESS: bri_q     <= cfg_wdata[LEVEL_W-1:0];
          CFG_TINT_COLOR: tint_q    <= cfg_wdata[23:0];
          CFG_TINT_EN:    tint_on_q <= cfg_wdata[0];
          CFG_TINT_WGT:   wgt_q     <= cfg_wdata[LEVEL_W-1:0];
          default: ;
        endcase
      end
    end
    pending = color_q.size();
  end

endmodule

[test/testbench.sv]
`timescale 1ns / 1ps
// testbench: stimulus and verdict for rainbow_wave_key_color_unit
// depends on rwkc_pkg, the unit itself and rwkc_checker

module testbench;
  import rwkc_pkg::*;

  localparam int PIPE_LAT       = 5;       // five register stages
  localparam int LIMIT_CYCLES   = 200000;
  localparam int LONG_HOLD      = 60;      // long enough to fill the pipe
  localparam int RAND_PHASES    = 8;
  localparam int REQS_PER_PHASE = 185;

  // no register sits at this index, writes to it must be dropped
  localparam logic [CIDX_W-1:0] CFG_UNMAPPED = 3'd7;
  // one sixth of a turn, steps one hue sector per tick
  localparam logic [31:0]       SIXTH_TURN   = 32'h002A_AAAB;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic [7:0]        in_key_index;
  logic [31:0]       in_time_ticks;
  logic              out_valid;
  logic              out_stall;
  logic [CHAN_W-1:0] out_red;
  logic [CHAN_W-1:0] out_green;
  logic [CHAN_W-1:0] out_blue;
  logic              cfg_we;
  logic [CIDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]  cfg_wdata;

  int fail_count;
  int pending;
  int cycle_count = 0;

  // random idling on each side, switched off now and then for full-rate stretches
  bit tx_gaps  = 1'b1;
  bit rx_gaps  = 1'b1;
  // asks the result side for one long hold-off
  bit hold_req = 1'b0;

  always #10 clk = ~clk;

  rainbow_wave_key_color_unit DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_key_index  (in_key_index),
    .in_time_ticks (in_time_ticks),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_red       (out_red),
    .out_green     (out_green),
    .out_blue      (out_blue),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata)
  );

  rwkc_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_key_index  (in_key_index),
    .in_time_ticks (in_time_ticks),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_red       (out_red),
    .out_green     (out_green),
    .out_blue      (out_blue),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .fail_count    (fail_count),
    .pending       (pending)
  );

  // watchdog, a hung handshake ends the run here
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // result side: random stall before each color while rx_gaps is set, or one long hold on request
  initial begin : result_sink
    int n;
    out_stall = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        n = rx_gaps ? $urandom_range(0, 7) : 0;
        if (n != 0) begin
          out_stall <= 1'b1;
          repeat (n) @(negedge clk);
        end
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  // entered and left on a falling edge; valid stays high after the
  // request so back-to-back requests never drop it
  task automatic send_req(input logic [7:0] key, input logic [31:0] ticks);
    int gap;
    gap = tx_gaps ? $urandom_range(0, 7) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_key_index  <= key;
    in_time_ticks <= ticks;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // drop valid and wait until every color is out and the pipe has settled
  task automatic drain_colors();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (PIPE_LAT + 3) @(negedge clk);
  endtask

  // bits above the register width carry noise, the unit must ignore them
  task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [31:0] value, input int w);
    logic [31:0] noise;
    noise     = $urandom();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= (noise << w) | value;
    @(negedge clk);
  endtask

  task automatic apply_settings(input logic [31:0] speed, input logic [31:0] scale,
                                input logic [8:0] sat, input logic [8:0] bri,
                                input logic [23:0] tint, input logic tint_on,
                                input logic [8:0] wgt);
    write_reg(CFG_WAVE_SPEED, speed, 32);
    write_reg(CFG_WAVE_SCALE, scale, 32);
    write_reg(CFG_SATURATION, 32'(sat), LEVEL_W);
    write_reg(CFG_BRIGHTNESS, 32'(bri), LEVEL_W);
    write_reg(CFG_TINT_COLOR, 32'(tint), 24);
    write_reg(CFG_TINT_EN, 32'(tint_on), 1);
    write_reg(CFG_TINT_WGT, 32'(wgt), LEVEL_W);
    // last, so a write that lands anywhere would stick
    write_reg(CFG_UNMAPPED, $urandom(), 0);
    cfg_we <= 1'b0;
  endtask

  // levels favor zero, full and the clamped range above full
  function automatic logic [8:0] rand_level();
    case ($urandom_range(0, 5))
      0:       return 9'd0;
      1:       return 9'd256;
      2:       return 9'd511;
      3:       return 9'($urandom_range(257, 511));
      default: return 9'($urandom_range(0, 256));
    endcase
  endfunction

  function automatic logic [31:0] rand_rate();
    case ($urandom_range(0, 5))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'($urandom_range(0, 32'h00FF_FFFF));   // under one turn
      3:       return -32'($urandom_range(1, 32'h00FF_FFFF));  // backward
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [31:0] rand_ticks();
    case ($urandom_range(0, 9))
      0:       return 32'd0;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'($urandom_range(0, 15));
      default: return $urandom();
    endcase
  endfunction

  initial begin : stimulus
    int ph;
    int i;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_key_index  = '0;
    in_time_ticks = '0;
    cfg_we        = 1'b0;
    cfg_index     = '0;
    cfg_wdata     = '0;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // register defaults: zero rates, so every key is pure red
    send_req(8'd0, 32'd0);
    send_req(8'd255, 32'hFFFF_FFFF);
    send_req(8'h80, 32'h8000_0000);
    drain_colors();

    // walk all six sectors and wrap, negative key phase, saturation above full
    apply_settings(SIXTH_TURN, -SIXTH_TURN, 9'd300, 9'd256, 24'h0, 1'b0, 9'd128);
    for (i = 0; i < 7; i++)
      send_req(8'd0, 32'(i));
    send_req(8'd1, 32'd0);
    send_req(8'd2, 32'd0);
    send_req(8'd255, 32'hFFFF_FFFF);
    drain_colors();

    // rate extremes, zero saturation, brightness and tint weight above full
    apply_settings(32'h8000_0000, 32'h7FFF_FFFF, 9'd0, 9'd511, 24'hFF_FFFF, 1'b1, 9'd511);
    send_req(8'd255, 32'd0);
    send_req(8'd0, 32'd1);
    send_req(8'd1, 32'd1);
    send_req(8'd255, 32'hFFFF_FFFF);
    drain_colors();

    // black value with tint at zero weight
    apply_settings(32'h0155_5555, 32'h0100_0000, 9'd128, 9'd0, 24'h12_3456, 1'b1, 9'd0);
    send_req(8'd7, 32'd3);
    send_req(8'd200, 32'h1234_5678);
    drain_colors();

    // full tint weight
    apply_settings(32'h7FFF_FFFF, 32'h8000_0000, 9'd256, 9'd200, 24'hA5_5AC3, 1'b1, 9'd256);
    send_req(8'd3, 32'd9);
    send_req(8'd128, 32'hDEAD_BEEF);
    send_req(8'd255, 32'h0000_0001);
    drain_colors();

    // random settings per phase, random keys and times within
    for (ph = 0; ph < RAND_PHASES; ph++) begin
      apply_settings(rand_rate(), rand_rate(), rand_level(), rand_level(),
                     24'($urandom()), 1'($urandom_range(0, 1)), rand_level());
      for (i = 0; i < REQS_PER_PHASE; i++) begin
        // reshuffle idling, a quarter of the stretches run at full rate
        if (i % 32 == 0) begin
          tx_gaps = ($urandom_range(0, 3) != 0);
          rx_gaps = ($urandom_range(0, 3) != 0);
        end
        // long hold on the result side while requests keep coming, backs up the pipe
        if (ph == 1 && i == 40) begin
          tx_gaps  = 1'b0;
          hold_req = 1'b1;
        end
        // sender pause until every color is out, then resume mid-phase
        if (ph == 4 && i == 90)
          drain_colors();
        send_req(8'($urandom_range(0, 255)), rand_ticks());
      end
      drain_colors();
    end

    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (PIPE_LAT * 4) @(negedge clk);
    if (fail_count == 0 && pending == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
